[rtl/core/tcf_pkg.sv]
// Package for the continued fraction tangent block: field widths, fixed point
// constants, divider control types and the microcode table of the sequencer.
// Depends on nothing.
`timescale 1ns / 1ps

package tcf_pkg;

	localparam int ANGLE_W   = 17;
	localparam int TAN_W     = 19;
	localparam int TERM_W    = 4;
	localparam int FRAC      = 24;
	localparam int A_W       = 25;
	localparam int QUO_W     = 32;
	localparam int CNT_W     = 6;
	localparam int PC_W      = 4;

	localparam logic [TERM_W-1:0]  TERM_RESET = 4'd9;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 17'd91750;
	localparam logic [TAN_W-1:0]   TAN_MAX    = 19'h7FFFF;
	localparam logic [CNT_W-1:0]   LEVEL_BITS = 6'd25;
	localparam logic [CNT_W-1:0]   FINAL_BITS = 6'd32;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t STEP_ACCEPT     = 4'd0;
	localparam pc_t STEP_MUL        = 4'd1;
	localparam pc_t STEP_DEEP       = 4'd2;
	localparam pc_t STEP_DEEP_WAIT  = 4'd3;
	localparam pc_t STEP_LEVEL_TEST = 4'd4;
	localparam pc_t STEP_LEVEL      = 4'd5;
	localparam pc_t STEP_LEVEL_WAIT = 4'd6;
	localparam pc_t STEP_FINAL      = 4'd7;
	localparam pc_t STEP_FINAL_WAIT = 4'd8;
	localparam pc_t STEP_EMIT       = 4'd9;

	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_MUL,
		OP_DIV_DEEP,
		OP_DIV_LEVEL,
		OP_DIV_FINAL,
		OP_WAIT_DIV,
		OP_NOP,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_BYPASS,
		COND_TOP,
		COND_FAULT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
	} div_sts_t;

	// Jumps are taken only when the step completes and its condition holds.
	function automatic ucode_t ucode_rom(pc_t pc);
		ucode_t w;
		case (pc)
			STEP_ACCEPT:     w = '{OP_ACCEPT,    COND_NEVER,  STEP_ACCEPT};
			STEP_MUL:        w = '{OP_MUL,       COND_BYPASS, STEP_EMIT};
			STEP_DEEP:       w = '{OP_DIV_DEEP,  COND_NEVER,  STEP_ACCEPT};
			STEP_DEEP_WAIT:  w = '{OP_WAIT_DIV,  COND_NEVER,  STEP_ACCEPT};
			STEP_LEVEL_TEST: w = '{OP_NOP,       COND_TOP,    STEP_FINAL};
			STEP_LEVEL:      w = '{OP_DIV_LEVEL, COND_FAULT,  STEP_EMIT};
			STEP_LEVEL_WAIT: w = '{OP_WAIT_DIV,  COND_ALWAYS, STEP_LEVEL_TEST};
			STEP_FINAL:      w = '{OP_DIV_FINAL, COND_FAULT,  STEP_EMIT};
			STEP_FINAL_WAIT: w = '{OP_WAIT_DIV,  COND_NEVER,  STEP_ACCEPT};
			STEP_EMIT:       w = '{OP_EMIT,      COND_ALWAYS, STEP_ACCEPT};
			default:         w = '{OP_NOP,       COND_ALWAYS, STEP_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

[rtl/core/tcf_in_if.sv]
// Request channel carrying one angle to the tangent block.
// Depends on tcf_pkg for the field width.
`timescale 1ns / 1ps

interface tcf_in_if;
	logic                        valid;
	logic                        ready;
	logic [tcf_pkg::ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

[rtl/core/tcf_out_if.sv]
// Result channel carrying the tangent and its flags out of the tangent block.
// Depends on tcf_pkg for the field width.
`timescale 1ns / 1ps

interface tcf_out_if;
	logic                      valid;
	logic                      ready;
	logic [tcf_pkg::TAN_W-1:0] tangent;
	logic                      angle_error;
	logic                      saturated;

	modport source (output valid, output tangent, output angle_error, output saturated,
		input ready);
	modport sink (input valid, input tangent, input angle_error, input saturated,
		output ready);
endinterface

[rtl/core/tangent_continued_fraction.sv]
// Top level of the continued fraction tangent block: microcoded sequencer,
// squaring multiplier, result register. Depends on tcf_pkg, tcf_in_if,
// tcf_out_if and tcf_div.
`timescale 1ns / 1ps

// Usage
// An angle request arrives on angle_ch (unsigned Q1.16 radians) and one result
// leaves on result_ch: tangent in unsigned Q3.16 with the angle_error and
// saturated flags. Both channels move a request at a clock edge where valid and
// ready are high. term_count is written through cfg_we and cfg_wdata while the
// block is idle; it resets to nine levels and is clamped to 1..MAX_LEVELS.
// The block works on one angle at a time. From acceptance to the result
// register, each level runs one division on the shared restoring divider,
// which produces one quotient bit per cycle: 25 bits for each level and 32
// bits for the final quotient, plus the sequencer steps around each division.
// A rejected angle or a single level skips the divisions.
// The result sits in an output register. The next angle is accepted as soon as
// the sequencer returns to its first step, even while that result is still
// waiting; if the receiver stalls, the following result holds the sequencer
// at its emit step until the register frees up. Reset empties the result
// register, returns the sequencer to its first step and restores term_count.
module tangent_continued_fraction #(
	parameter int MAX_LEVELS = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcf_pkg::TERM_W-1:0]  cfg_wdata,
	tcf_in_if.sink                      angle_ch,
	tcf_out_if.source                   result_ch
);
	import tcf_pkg::*;

	// Level count, continued fraction denominator and divider widths.
	localparam int LW   = $clog2(MAX_LEVELS + 1);
	localparam int BW   = $clog2(2 * MAX_LEVELS);
	localparam int CW   = (LW > TERM_W) ? LW : TERM_W;
	localparam int DENW = BW + FRAC;
	localparam logic [DENW-1:0] ONE_DEN = DENW'(1) << FRAC;

	// Configuration register.
	logic [TERM_W-1:0] term_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_RESET;
		end else if (cfg_we) begin
			term_count_q <= cfg_wdata;
		end
	end

	// Sequencer state.
	pc_t    pc_q;
	ucode_t uw;
	logic   step_go;
	logic   cond_true;
	logic   fault;

	// Per angle working registers.
	logic [ANGLE_W-1:0] angle_q;
	logic [A_W-1:0]     a_q;
	logic [BW-1:0]      b_q;
	logic [LW-1:0]      k_q;
	logic               angle_bad_q;
	logic               single_q;
	logic               fault_q;

	// Result register.
	logic               out_valid_q;
	logic [TAN_W-1:0]   tangent_q;
	logic               angle_error_q;
	logic               saturated_q;

	// Divider connection.
	div_ctl_t           div_ctl;
	div_sts_t           div_sts;
	logic [DENW-1:0]    div_rem;
	logic [QUO_W-1:0]   div_low;
	logic [DENW-1:0]    div_den;
	logic [QUO_W-1:0]   div_quo;

	logic [CW-1:0]          tc_ext;
	logic [LW-1:0]          levels;
	logic [BW-1:0]          b_first;
	logic [BW-1:0]          b_next;
	logic [DENW-1:0]        cf_ext;
	logic [DENW-1:0]        level_bq;
	logic [2*ANGLE_W-1:0]   square;
	logic                   angle_bad;
	logic                   out_free;
	logic [TAN_W-1:0]       emit_tangent;
	logic                   emit_error;
	logic                   emit_sat;

	assign uw = ucode_rom(pc_q);

	// Clamp the configured level count into 1..MAX_LEVELS.
	always_comb begin
		tc_ext = CW'(term_count_q);
		if (tc_ext == '0) begin
			levels = LW'(1);
		end else if (tc_ext > CW'(MAX_LEVELS)) begin
			levels = LW'(MAX_LEVELS);
		end else begin
			levels = LW'(tc_ext);
		end
	end

	assign b_first   = BW'({levels, 1'b0} - 1'b1);
	assign b_next    = b_q - BW'(2);
	assign angle_bad = (angle_ch.angle == '0) || (angle_ch.angle > ANGLE_MAX);

	// The running fraction is the low part of the last quotient; it always
	// fits in 25 bits.
	assign cf_ext   = DENW'(div_quo[A_W-1:0]);
	assign level_bq = {b_next, {FRAC{1'b0}}};
	assign square   = {{ANGLE_W{1'b0}}, angle_q} * {{ANGLE_W{1'b0}}, angle_q};

	// A denominator that is not positive aborts the evaluation.
	always_comb begin
		case (uw.op)
			OP_DIV_LEVEL: fault = (cf_ext >= level_bq);
			OP_DIV_FINAL: fault = (cf_ext >= ONE_DEN);
			default:      fault = 1'b0;
		endcase
	end

	assign out_free = ~out_valid_q | result_ch.ready;

	always_comb begin
		case (uw.op)
			OP_ACCEPT:   step_go = angle_ch.valid;
			OP_WAIT_DIV: step_go = ~div_sts.busy;
			OP_EMIT:     step_go = out_free;
			default:     step_go = 1'b1;
		endcase
	end

	always_comb begin
		case (uw.cond)
			COND_NEVER:  cond_true = 1'b0;
			COND_ALWAYS: cond_true = 1'b1;
			COND_BYPASS: cond_true = angle_bad_q | single_q;
			COND_TOP:    cond_true = (k_q < LW'(2));
			COND_FAULT:  cond_true = fault;
			default:     cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_ACCEPT;
		end else if (step_go) begin
			pc_q <= cond_true ? uw.target : pc_q + 1'b1;
		end
	end

	// Divider operands. Deepest level: a / b. Upper levels:
	// (a << 24) / ((b << 24) - cf). Top: (x << 24) / (1 - cf), x = angle << 8.
	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.nbits = LEVEL_BITS;
		div_rem       = '0;
		div_low       = '0;
		div_den       = ONE_DEN - cf_ext;
		case (uw.op)
			OP_DIV_DEEP: begin
				div_ctl.start = 1'b1;
				div_low       = {a_q, {(QUO_W-A_W){1'b0}}};
				div_den       = DENW'(b_q);
			end
			OP_DIV_LEVEL: begin
				div_ctl.start = ~fault;
				div_rem       = DENW'(a_q[A_W-1:1]);
				div_low       = {a_q[0], {(QUO_W-1){1'b0}}};
				div_den       = level_bq - cf_ext;
			end
			OP_DIV_FINAL: begin
				div_ctl.start = ~fault;
				div_ctl.nbits = FINAL_BITS;
				div_rem       = DENW'(angle_q);
			end
			default: begin
				div_ctl.start = 1'b0;
			end
		endcase
	end

	tcf_div #(
		.DENW(DENW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem),
		.low_init (div_low),
		.den      (div_den),
		.sts      (div_sts),
		.quo      (div_quo)
	);

	// Working registers are payload and need no reset.
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				if (angle_ch.valid) begin
					angle_q     <= angle_ch.angle;
					angle_bad_q <= angle_bad;
					single_q    <= (levels == LW'(1));
					fault_q     <= 1'b0;
					k_q         <= levels - 1'b1;
					b_q         <= b_first;
				end
			end
			OP_MUL: begin
				// a = (x * x) >> 24 with x = angle << 8.
				a_q <= square[A_W+7:8];
			end
			OP_DIV_LEVEL: begin
				b_q     <= b_next;
				k_q     <= k_q - 1'b1;
				fault_q <= fault;
			end
			OP_DIV_FINAL: begin
				fault_q <= fault;
			end
			default: begin
			end
		endcase
	end

	// Result selection at the emit step.
	always_comb begin
		emit_tangent = '0;
		emit_error   = 1'b0;
		emit_sat     = 1'b0;
		if (angle_bad_q) begin
			emit_error = 1'b1;
		end else if (single_q) begin
			emit_tangent = TAN_W'(angle_q);
		end else if (fault_q || (div_quo[QUO_W-1:TAN_W+8] != '0)) begin
			emit_tangent = TAN_MAX;
			emit_sat     = 1'b1;
		end else begin
			emit_tangent = div_quo[TAN_W+7:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_EMIT && out_free) begin
			tangent_q     <= emit_tangent;
			angle_error_q <= emit_error;
			saturated_q   <= emit_sat;
		end
	end

	assign angle_ch.ready        = (uw.op == OP_ACCEPT);
	assign result_ch.valid       = out_valid_q;
	assign result_ch.tangent     = tangent_q;
	assign result_ch.angle_error = angle_error_q;
	assign result_ch.saturated   = saturated_q;

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_ch.valid && angle_ch.ready) |=> !angle_ch.ready)
		else $error("second angle accepted before the first finished");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.saturated) |->
		(result_ch.tangent == TAN_MAX && !result_ch.angle_error))
		else $error("saturated result without maximum tangent");

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.angle_error) |->
		(result_ch.tangent == '0 && !result_ch.saturated))
		else $error("rejected angle with nonzero result");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_EMIT)
		else $error("sequencer left its program");
`endif

endmodule

[rtl/core/tcf_div.sv]
// Restoring divider of the tangent block, one quotient bit per cycle.
// Depends on tcf_pkg for the control and status structs.
`timescale 1ns / 1ps

module tcf_div #(
	parameter int DENW = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcf_pkg::div_ctl_t           ctl,
	input  logic [DENW-1:0]             rem_init,
	input  logic [tcf_pkg::QUO_W-1:0]   low_init,
	input  logic [DENW-1:0]             den,
	output tcf_pkg::div_sts_t           sts,
	output logic [tcf_pkg::QUO_W-1:0]   quo
);
	import tcf_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DENW-1:0]  rem_q;
	logic [DENW-1:0]  den_q;
	logic [QUO_W-1:0] low_q;
	logic [DENW:0]    shifted;
	logic [DENW+1:0]  diff;
	logic             qbit;

	// The partial remainder stays below the divisor, so the shifted value
	// needs one extra bit and the trial difference one more for its sign.
	assign shifted = {rem_q, low_q[QUO_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign qbit    = ~diff[DENW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ctl.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init;
			low_q <= low_init;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DENW-1:0] : shifted[DENW-1:0];
			low_q <= {low_q[QUO_W-2:0], qbit};
		end
	end

	assign sts.busy = busy_q;
	assign quo      = low_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the continued fraction tangent block.
// Depends on tcf_pkg, tcf_in_if, tcf_out_if and tangent_continued_fraction.
`timescale 1ns / 1ps

module tb_top;
	import tcf_pkg::*;

	// The block clamps the level count to this value, matching its default parameter.
	localparam int LEVEL_CAP    = 13;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 2;
	// Longer than the slowest request, at thirteen levels, so this tail covers any straggler.
	localparam int TAIL_CYCLES  = 400;
	// Slowest legal run: about 1900 requests, all at thirteen levels, plus handshake
	// stalls. The cap leaves a wide margin above that.
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int PHASES       = 3;
	localparam int SEGMENTS     = 12;
	localparam int SEG_ITEMS    = 52;

	localparam logic [TERM_W-1:0] TERM_ZERO  = 4'd0;
	localparam logic [TERM_W-1:0] TERM_ONE   = 4'd1;
	localparam logic [TERM_W-1:0] TERM_TWO   = 4'd2;
	localparam logic [TERM_W-1:0] TERM_DEEP  = 4'd13;
	localparam logic [TERM_W-1:0] TERM_FULL  = 4'd15;

	typedef struct packed {
		logic [TAN_W-1:0] tangent;
		logic             angle_error;
		logic             saturated;
	} tan_result_t;

	// One directed request. A row with set_term writes the register first, once
	// the block has drained. A row with typed holds a result read straight off
	// the spec; all other rows fall back on the predictor.
	typedef struct {
		logic               set_term;
		logic [TERM_W-1:0]  term;
		logic [ANGLE_W-1:0] angle;
		logic               typed;
		tan_result_t        res;
	} angle_row_t;

	typedef struct packed {
		logic        typed;
		tan_result_t res;
	} typed_tag_t;

	localparam tan_result_t REJECTED = '{tangent: '0, angle_error: 1'b1, saturated: 1'b0};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [TERM_W-1:0] cfg_wdata;

	tcf_in_if  angle_if ();
	tcf_out_if result_if ();

	tangent_continued_fraction i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.angle_ch  (angle_if),
		.result_ch (result_if)
	);

	always #HALF_PERIOD clk = ~clk;

	// Expected results in the order their requests were accepted.
	tan_result_t tangent_q[$];
	// Typed results for directed requests, consumed at acceptance.
	typed_tag_t typed_q[$];

	logic [TERM_W-1:0] levels_shadow = TERM_RESET;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_fail = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int n_saturated = 0;
	int n_single = 0;
	int cycle_count = 0;

	// Lambert's continued fraction evaluated bottom-up in Q.24 with truncating
	// division, exactly as the block should do it.
	function automatic tan_result_t lambert_tangent(logic [ANGLE_W-1:0] angle,
		logic [TERM_W-1:0] term);
		tan_result_t r;
		int levels;
		logic [63:0] x, a, cf, b, bq, t;
		r = '{tangent: '0, angle_error: 1'b0, saturated: 1'b0};
		if (angle == '0 || angle > ANGLE_MAX) begin
			r.angle_error = 1'b1;
			return r;
		end
		levels = (term == 0) ? 1 : int'(term);
		if (levels > LEVEL_CAP)
			levels = LEVEL_CAP;
		// A single level is just x / 1, returned without rounding loss.
		if (levels == 1) begin
			r.tangent = TAN_W'(angle);
			return r;
		end
		x  = 64'(angle) << 8;
		a  = (x * x) >> FRAC;
		b  = 64'(2 * levels - 1);
		cf = a / b;
		for (int k = levels - 1; k >= 2; k--) begin
			b  = b - 64'd2;
			bq = b << FRAC;
			// A denominator at or below zero cannot occur for legal angles, but the
			// block still defines it as a saturated result.
			if (cf >= bq) begin
				r.tangent = TAN_MAX;
				r.saturated = 1'b1;
				return r;
			end
			cf = (a << FRAC) / (bq - cf);
		end
		bq = 64'd1 << FRAC;
		if (cf >= bq) begin
			r.tangent = TAN_MAX;
			r.saturated = 1'b1;
			return r;
		end
		t = ((x << FRAC) / (bq - cf)) >> 8;
		if (t > 64'(TAN_MAX)) begin
			r.tangent = TAN_MAX;
			r.saturated = 1'b1;
		end else begin
			r.tangent = TAN_W'(t);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		n_fail++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Random angle: mostly legal angles, some near the legal edges, and a share
	// drawn from the whole field so that every bit and the rejection path are hit.
	function automatic logic [ANGLE_W-1:0] pick_angle();
		int sel;
		sel = $urandom_range(99);
		if (sel < 78)
			return ANGLE_W'($urandom_range(int'(ANGLE_MAX), 1));
		else if (sel < 82)
			return ANGLE_W'($urandom_range(16, 0));
		else if (sel < 86)
			return ANGLE_W'($urandom_range(int'(ANGLE_MAX) + 10, int'(ANGLE_MAX) - 10));
		else
			return ANGLE_W'($urandom);
	endfunction

	// The receiver decides its ready for the next edge at every falling edge.
	always @(negedge clk) begin
		if (arst_n)
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Everything is sampled at the rising edge; the stimulus only moves on the
	// falling edge, so the sampled values are stable here.
	always @(posedge clk) begin
		typed_tag_t  tag;
		tan_result_t want;
		if (arst_n) begin
			if (cfg_we)
				levels_shadow = cfg_wdata;
			if (angle_if.valid && angle_if.ready) begin
				want = lambert_tangent(angle_if.angle, levels_shadow);
				if (typed_q.size() != 0) begin
					tag = typed_q.pop_front();
					if (tag.typed)
						want = tag.res;
				end
				tangent_q.push_back(want);
				n_sent++;
			end
			if (result_if.valid && result_if.ready) begin
				if (tangent_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result tangent=%0d err=%0b sat=%0b",
						result_if.tangent, result_if.angle_error, result_if.saturated));
				end else begin
					want = tangent_q.pop_front();
					n_checked++;
					if (want.angle_error)
						n_rejected++;
					if (want.saturated)
						n_saturated++;
					if (result_if.tangent !== want.tangent)
						report_mismatch($sformatf("result %0d: tangent %0d, expected %0d",
							n_checked, result_if.tangent, want.tangent));
					if (result_if.angle_error !== want.angle_error)
						report_mismatch($sformatf("result %0d: angle_error %0b, expected %0b",
							n_checked, result_if.angle_error, want.angle_error));
					if (result_if.saturated !== want.saturated)
						report_mismatch($sformatf("result %0d: saturated %0b, expected %0b",
							n_checked, result_if.saturated, want.saturated));
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				tangent_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Presents one request. Called at a falling edge; returns at the falling edge
	// after acceptance with valid still high, so back-to-back requests never drop
	// valid inside one time step.
	task automatic send_angle(input logic [ANGLE_W-1:0] angle);
		if ($urandom_range(99) < send_idle_pct) begin
			angle_if.valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		angle_if.valid <= 1'b1;
		angle_if.angle <= angle;
		@(posedge clk);
		while (!angle_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Lets the block drain completely, then writes term_count. Every request
	// yields a result, so an empty expectation queue means the block is idle.
	// This is also where the sender holds off until all results are back.
	task automatic set_levels(input logic [TERM_W-1:0] term);
		angle_if.valid <= 1'b0;
		while (tangent_q.size() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= term;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	angle_row_t directed[] = '{
		// Reset value of nine levels: both rejection edges, the all-ones angle and three legal angles.
		'{1'b0, TERM_ZERO, 17'd0,      1'b1, REJECTED},
		'{1'b0, TERM_ZERO, 17'd91751,  1'b1, REJECTED},
		'{1'b0, TERM_ZERO, 17'h1FFFF,  1'b1, REJECTED},
		'{1'b0, TERM_ZERO, 17'd1,      1'b0, REJECTED},
		'{1'b0, TERM_ZERO, 17'd51472,  1'b0, REJECTED},
		'{1'b0, TERM_ZERO, 17'd91750,  1'b0, REJECTED},
		// A single level hands the angle straight back and still rejects a zero angle.
		'{1'b1, TERM_ONE,  17'd1,      1'b1, '{19'd1, 1'b0, 1'b0}},
		'{1'b0, TERM_ONE,  17'd91750,  1'b1, '{19'd91750, 1'b0, 1'b0}},
		'{1'b0, TERM_ONE,  17'd65536,  1'b1, '{19'd65536, 1'b0, 1'b0}},
		'{1'b0, TERM_ONE,  17'd0,      1'b1, REJECTED},
		// A zero level count behaves as one level.
		'{1'b1, TERM_ZERO, 17'd12345,  1'b1, '{19'd12345, 1'b0, 1'b0}},
		'{1'b0, TERM_ZERO, 17'd91751,  1'b1, REJECTED},
		// Two levels, the shallowest real fraction, from the top of the range down to the smallest angle.
		'{1'b1, TERM_TWO,  17'd91750,  1'b0, REJECTED},
		'{1'b0, TERM_TWO,  17'd32768,  1'b0, REJECTED},
		'{1'b0, TERM_TWO,  17'd1,      1'b0, REJECTED},
		// Deepest supported fraction.
		'{1'b1, TERM_DEEP, 17'd91750,  1'b0, REJECTED},
		'{1'b0, TERM_DEEP, 17'd1,      1'b0, REJECTED},
		'{1'b0, TERM_DEEP, 17'd65536,  1'b0, REJECTED},
		'{1'b0, TERM_DEEP, 17'h10000,  1'b0, REJECTED},
		// Counts above the cap are clamped to it.
		'{1'b1, TERM_FULL, 17'd91750,  1'b0, REJECTED},
		'{1'b0, TERM_FULL, 17'd43690,  1'b0, REJECTED},
		'{1'b0, TERM_FULL, 17'd131070, 1'b1, REJECTED}
	};

	logic [TERM_W-1:0] seg_terms[5] = '{TERM_ZERO, TERM_FULL, TERM_ONE, TERM_DEEP, TERM_TWO};

	initial begin
		int seg_index;
		// Every input is known from time zero; reset is applied once.
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		angle_if.valid   = 1'b0;
		angle_if.angle   = '0;
		result_if.ready  = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests run without idling on either side.
		foreach (directed[i]) begin
			if (directed[i].set_term)
				set_levels(directed[i].term);
			typed_q.push_back('{typed: directed[i].typed, res: directed[i].res});
			if (directed[i].typed && directed[i].term <= TERM_ONE && !directed[i].res.angle_error)
				n_single++;
			send_angle(directed[i].angle);
		end

		// Random part in three idling regimes, each split into segments that start
		// from a drained block with a fresh level count. The first segments force
		// the extreme counts, the rest draw any 4-bit value.
		seg_index = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				if (seg_index < $size(seg_terms))
					set_levels(seg_terms[seg_index]);
				else
					set_levels(TERM_W'($urandom_range(15)));
				seg_index++;
				for (int k = 0; k < SEG_ITEMS; k++)
					send_angle(pick_angle());
			end
		end

		angle_if.valid <= 1'b0;
		while (tangent_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d angle requests over %0d level settings and three idling regimes.",
			n_sent, seg_index + 5);
		$display("Checked %0d results: %0d rejected angles, %0d saturated, %0d mismatches.",
			n_checked, n_rejected, n_saturated, n_fail);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[tangent_continued_fraction.f]
rtl/core/tcf_pkg.sv
rtl/core/tcf_in_if.sv
rtl/core/tcf_out_if.sv
rtl/core/tcf_div.sv
rtl/core/tangent_continued_fraction.sv
tb/tb_top.sv
